/* hdl/hmmfb_pkg.sv */
`timescale 1ns / 1ps

package hmmfb_pkg;

    localparam int MAX_STATES = 8;
    localparam int MAX_STEPS  = 256;
    localparam int FRAC_BITS  = 32;

    localparam int DW       = 64;
    localparam int ST_W     = $clog2(MAX_STATES);
    localparam int NS_W     = $clog2(MAX_STATES + 1);
    localparam int STEP_W   = $clog2(MAX_STEPS);
    localparam int LEN_W    = $clog2(MAX_STEPS + 1);
    localparam int ST_DEPTH = MAX_STEPS * MAX_STATES;
    localparam int TR_DEPTH = MAX_STEPS * MAX_STATES * MAX_STATES;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int TR_AW    = $clog2(TR_DEPTH);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOMOG   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NSTATES = 1'd1;
    localparam logic [3:0] NSTATES_RST = 4'd8;

    localparam logic [2:0] K_INIT  = 3'd0;
    localparam logic [2:0] K_TRANS = 3'd1;
    localparam logic [2:0] K_DENS  = 3'd2;
    localparam logic [2:0] K_RUN   = 3'd3;
    localparam logic [2:0] K_READ  = 3'd4;

    localparam logic [1:0] W_ALPHA = 2'd0;
    localparam logic [1:0] W_BETA  = 2'd1;
    localparam logic [1:0] W_SCALE = 2'd2;
    localparam logic [1:0] W_XI    = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    localparam logic [DW-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  step_index;
        logic [2:0]  from_state;
        logic [2:0]  to_state;
        logic [63:0] data_value;
        logic [8:0]  seq_length;
        logic [1:0]  which_array;
    } in_item_t;

    typedef struct packed {
        logic [63:0] read_value;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic fill;
        logic copy;
        logic rot;
        logic push;
    } cell_ctrl_t;

    function automatic logic [ST_AW-1:0] st_addr(input int unsigned step,
                                                 input int unsigned st);
        return ST_AW'(step * MAX_STATES + st);
    endfunction

    function automatic logic [TR_AW-1:0] tr_addr(input int unsigned step,
                                                 input int unsigned from,
                                                 input int unsigned to);
        return TR_AW'((step * MAX_STATES + from) * MAX_STATES + to);
    endfunction

endpackage

/* hdl/hmm_scaled_forward_backward.sv */
`timescale 1ns / 1ps
// channel   ports                           request
// --------  ------------------------------  ------------------------------------
// input     s_valid s_ready s_data          load, run or read item
// result    m_valid m_ready m_data          read value and status, one each
// config    cfg_we cfg_index cfg_data       register write, no handshake
//
// A run's time goes to the forward and backward passes plus a reciprocal per step;
// the shared 4-pass multiplier sets the pace.
// Synchronous active-low reset clears control and flags, not the stores.
// A result held by a stalled m_ready does not block acceptance of the next request.

module hmm_scaled_forward_backward (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  hmmfb_pkg::in_item_t                s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output hmmfb_pkg::out_item_t               m_data,
    input  logic                               cfg_we,
    input  logic [hmmfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hmmfb_pkg::CFG_DW-1:0]       cfg_data
);
    import hmmfb_pkg::*;

    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_OUT    = 6'd1;
    localparam logic [5:0] S_F0_RD  = 6'd2;
    localparam logic [5:0] S_F0_MUL = 6'd3;
    localparam logic [5:0] S_F0_WT  = 6'd4;
    localparam logic [5:0] S_SC_REQ = 6'd5;
    localparam logic [5:0] S_SC_WT  = 6'd6;
    localparam logic [5:0] S_SC_WR  = 6'd7;
    localparam logic [5:0] S_SC_MUL = 6'd8;
    localparam logic [5:0] S_SC_WT2 = 6'd9;
    localparam logic [5:0] S_SC_CP  = 6'd10;
    localparam logic [5:0] S_FW_J   = 6'd11;
    localparam logic [5:0] S_FW_RD  = 6'd12;
    localparam logic [5:0] S_FW_M1  = 6'd13;
    localparam logic [5:0] S_FW_W1  = 6'd14;
    localparam logic [5:0] S_FW_DN  = 6'd15;
    localparam logic [5:0] S_FW_M2  = 6'd16;
    localparam logic [5:0] S_FW_W2  = 6'd17;
    localparam logic [5:0] S_BI_WR  = 6'd18;
    localparam logic [5:0] S_BW_I   = 6'd19;
    localparam logic [5:0] S_BW_RD  = 6'd20;
    localparam logic [5:0] S_BW_M1  = 6'd21;
    localparam logic [5:0] S_BW_W1  = 6'd22;
    localparam logic [5:0] S_BW_M2  = 6'd23;
    localparam logic [5:0] S_BW_W2  = 6'd24;
    localparam logic [5:0] S_BW_SC  = 6'd25;
    localparam logic [5:0] S_BW_M3  = 6'd26;
    localparam logic [5:0] S_BW_W3  = 6'd27;
    localparam logic [5:0] S_BW_FIN = 6'd28;
    localparam logic [5:0] S_RD_RD  = 6'd29;
    localparam logic [5:0] S_RD_DAT = 6'd30;
    localparam logic [5:0] S_XI_W1  = 6'd31;
    localparam logic [5:0] S_XI_M2  = 6'd32;
    localparam logic [5:0] S_XI_W2  = 6'd33;
    localparam logic [5:0] S_XI_M3  = 6'd34;
    localparam logic [5:0] S_XI_W3  = 6'd35;

    localparam logic [ST_W-1:0] IDX_LAST = ST_W'(MAX_STATES - 1);

    function automatic logic [1:0] code_of(input logic [1:0] flags);
        if (flags[1]) begin
            return STAT_ZERO;
        end
        if (flags[0]) begin
            return STAT_SAT;
        end
        return STAT_OK;
    endfunction

    function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {1'b1, ALL_ONES} : s;
    endfunction

    logic [5:0]        state_reg, state_next;
    logic [STEP_W-1:0] t_reg, t_next;
    logic [ST_W-1:0]   i_reg, i_next;
    logic [ST_W-1:0]   j_reg, j_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       sum_reg, sum_next;
    logic [63:0]       sc_reg, sc_next;
    logic [63:0]       tmp_reg, tmp_next;
    logic              sat_reg, sat_next;
    logic              zero_reg, zero_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    in_item_t          item_reg, item_next;
    logic [1:0]        run_flags_reg, run_flags_next;
    out_item_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;
    logic              homog_reg;
    logic [3:0]        nstates_reg;

    logic [NS_W-1:0]   ns;
    logic              i_lt, j_lt, i_last, j_last;
    logic [STEP_W-1:0] t_prev, tr_step, it_step;
    logic [LEN_W-1:0]  len_c;
    logic              step_ok, rd_ok, xi_ok;
    logic [64:0]       add_r;

    cell_ctrl_t  cell_ctrl;
    logic [63:0] push_val;
    logic [63:0] cell_prev [MAX_STATES];
    logic [63:0] cell_cur  [MAX_STATES];
    logic [63:0] prev0;

    logic        mul_start, mul_done, mul_sat;
    logic [63:0] mul_a, mul_b, mul_res;
    logic        rc_start, rc_done, rc_sat;
    logic [63:0] rc_q;

    logic              init_we, tr_we, dn_we, al_we, bt_we, sc_we;
    logic [ST_W-1:0]   init_ra;
    logic [TR_AW-1:0]  tr_wa, tr_ra;
    logic [ST_AW-1:0]  dn_wa, dn_ra, al_wa, al_ra, bt_wa, bt_ra;
    logic [STEP_W-1:0] sc_ra;
    logic [63:0]       init_rd, tr_rd, dn_rd, al_rd, bt_rd, sc_rd, bt_wd;

    always_comb begin
        if (nstates_reg == 4'd0) begin
            ns = NS_W'(1);
        end else if (32'(nstates_reg) > MAX_STATES) begin
            ns = NS_W'(MAX_STATES);
        end else begin
            ns = NS_W'(nstates_reg);
        end
        if (s_data.seq_length == 9'd0) begin
            len_c = LEN_W'(1);
        end else if (32'(s_data.seq_length) > MAX_STEPS) begin
            len_c = LEN_W'(MAX_STEPS);
        end else begin
            len_c = LEN_W'(s_data.seq_length);
        end
    end

    assign i_lt    = NS_W'(i_reg) < ns;
    assign j_lt    = NS_W'(j_reg) < ns;
    assign i_last  = i_reg == IDX_LAST;
    assign j_last  = j_reg == IDX_LAST;
    assign t_prev  = t_reg - 1'b1;
    assign tr_step = homog_reg ? '0 : t_prev;
    assign it_step = STEP_W'(item_reg.step_index);
    assign step_ok = 32'(item_reg.step_index) < MAX_STEPS;
    assign rd_ok   = step_ok && 32'(item_reg.from_state) < MAX_STATES;
    assign xi_ok   = rd_ok && 32'(item_reg.to_state) < MAX_STATES
                     && 32'(item_reg.step_index) + 1 < MAX_STEPS;
    assign prev0   = cell_prev[0];

    always_comb begin
        init_ra = j_reg;
        tr_ra   = tr_addr(homog_reg ? 0 : item_reg.step_index, item_reg.from_state,
                          item_reg.to_state);
        dn_ra   = st_addr(item_reg.step_index + 1, item_reg.to_state);
        al_ra   = st_addr(item_reg.step_index, item_reg.from_state);
        bt_ra   = (item_reg.which_array == W_BETA)
                  ? st_addr(item_reg.step_index, item_reg.from_state)
                  : st_addr(item_reg.step_index + 1, item_reg.to_state);
        sc_ra   = it_step;
        unique case (state_reg)
            S_F0_RD: dn_ra = st_addr(0, j_reg);
            S_FW_RD: tr_ra = tr_addr(tr_step, i_reg, j_reg);
            S_FW_DN: dn_ra = st_addr(t_reg, j_reg);
            S_BW_RD: begin
                tr_ra = tr_addr(tr_step, i_reg, j_reg);
                dn_ra = st_addr(t_reg, j_reg);
            end
            S_BW_SC: sc_ra = t_prev;
            default: ;
        endcase
    end

    assign tr_wa = tr_addr(s_data.step_index, s_data.from_state, s_data.to_state);
    assign dn_wa = st_addr(s_data.step_index, s_data.from_state);
    assign al_wa = st_addr(t_reg, i_reg);
    assign bt_wa = (state_reg == S_BW_W3) ? st_addr(t_prev, i_reg) : st_addr(t_reg, i_reg);
    assign bt_wd = (state_reg == S_BW_W3) ? mul_res : sc_reg;

    always_comb begin
        state_next     = state_reg;
        t_next         = t_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        sc_next        = sc_reg;
        tmp_next       = tmp_reg;
        sat_next       = sat_reg;
        zero_next      = zero_reg;
        len_next       = len_reg;
        item_next      = item_reg;
        run_flags_next = run_flags_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        cell_ctrl      = '0;
        push_val       = '0;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        rc_start       = 1'b0;
        init_we        = 1'b0;
        tr_we          = 1'b0;
        dn_we          = 1'b0;
        al_we          = 1'b0;
        bt_we          = 1'b0;
        sc_we          = 1'b0;
        add_r          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    res_next   = '0;
                    sat_next   = 1'b0;
                    state_next = S_OUT;
                    priority case (s_data.kind)
                        K_INIT: init_we = 32'(s_data.from_state) < MAX_STATES;
                        K_TRANS: tr_we = 32'(s_data.step_index) < MAX_STEPS
                                         && 32'(s_data.from_state) < MAX_STATES
                                         && 32'(s_data.to_state) < MAX_STATES;
                        K_DENS: dn_we = 32'(s_data.step_index) < MAX_STEPS
                                        && 32'(s_data.from_state) < MAX_STATES;
                        K_RUN: begin
                            len_next   = len_c;
                            t_next     = '0;
                            j_next     = '0;
                            sum_next   = '0;
                            zero_next  = 1'b0;
                            state_next = S_F0_RD;
                        end
                        K_READ: state_next = S_RD_RD;
                        default: ;
                    endcase
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            S_F0_RD: begin
                if (j_lt) begin
                    state_next = S_F0_MUL;
                end else begin
                    cell_ctrl.push = 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = j_last ? S_SC_REQ : S_F0_RD;
                end
            end
            S_F0_MUL: begin
                mul_start  = 1'b1;
                mul_a      = init_rd;
                mul_b      = dn_rd;
                state_next = S_F0_WT;
            end
            S_F0_WT: begin
                if (mul_done) begin
                    cell_ctrl.push = 1'b1;
                    push_val   = mul_res;
                    add_r      = sadd(sum_reg, mul_res);
                    sum_next   = add_r[63:0];
                    sat_next   = sat_reg | mul_sat | add_r[64];
                    j_next     = j_reg + 1'b1;
                    state_next = j_last ? S_SC_REQ : S_F0_RD;
                end
            end
            S_SC_REQ: begin
                if (sum_reg == '0) begin
                    sc_next    = ALL_ONES;
                    zero_next  = 1'b1;
                    state_next = S_SC_WR;
                end else begin
                    rc_start   = 1'b1;
                    state_next = S_SC_WT;
                end
            end
            S_SC_WT: begin
                if (rc_done) begin
                    sc_next    = rc_q;
                    sat_next   = sat_reg | rc_sat;
                    state_next = S_SC_WR;
                end
            end
            S_SC_WR: begin
                sc_we          = 1'b1;
                cell_ctrl.copy = 1'b1;
                i_next         = '0;
                state_next     = S_SC_MUL;
            end
            S_SC_MUL: begin
                if (i_lt) begin
                    mul_start  = 1'b1;
                    mul_a      = prev0;
                    mul_b      = sc_reg;
                    state_next = S_SC_WT2;
                end else begin
                    cell_ctrl.push = 1'b1;
                    cell_ctrl.rot  = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = i_last ? S_SC_CP : S_SC_MUL;
                end
            end
            S_SC_WT2: begin
                if (mul_done) begin
                    cell_ctrl.push = 1'b1;
                    cell_ctrl.rot  = 1'b1;
                    push_val   = mul_res;
                    al_we      = 1'b1;
                    sat_next   = sat_reg | mul_sat;
                    i_next     = i_reg + 1'b1;
                    state_next = i_last ? S_SC_CP : S_SC_MUL;
                end
            end
            S_SC_CP: begin
                cell_ctrl.copy = 1'b1;
                i_next         = '0;
                if (LEN_W'(t_reg) == len_reg - 1'b1) begin
                    state_next = S_BI_WR;
                end else begin
                    t_next     = t_reg + 1'b1;
                    j_next     = '0;
                    sum_next   = '0;
                    state_next = S_FW_J;
                end
            end
            S_FW_J: begin
                if (j_lt) begin
                    acc_next   = '0;
                    i_next     = '0;
                    state_next = S_FW_RD;
                end else begin
                    cell_ctrl.push = 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = j_last ? S_SC_REQ : S_FW_J;
                end
            end
            S_FW_RD: begin
                if (i_lt) begin
                    state_next = S_FW_M1;
                end else begin
                    cell_ctrl.rot = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = i_last ? S_FW_DN : S_FW_RD;
                end
            end
            S_FW_M1: begin
                mul_start  = 1'b1;
                mul_a      = tr_rd;
                mul_b      = prev0;
                state_next = S_FW_W1;
            end
            S_FW_W1: begin
                if (mul_done) begin
                    add_r      = sadd(acc_reg, mul_res);
                    acc_next   = add_r[63:0];
                    sat_next   = sat_reg | mul_sat | add_r[64];
                    cell_ctrl.rot = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = i_last ? S_FW_DN : S_FW_RD;
                end
            end
            S_FW_DN: state_next = S_FW_M2;
            S_FW_M2: begin
                mul_start  = 1'b1;
                mul_a      = acc_reg;
                mul_b      = dn_rd;
                state_next = S_FW_W2;
            end
            S_FW_W2: begin
                if (mul_done) begin
                    cell_ctrl.push = 1'b1;
                    push_val   = mul_res;
                    add_r      = sadd(sum_reg, mul_res);
                    sum_next   = add_r[63:0];
                    sat_next   = sat_reg | mul_sat | add_r[64];
                    j_next     = j_reg + 1'b1;
                    state_next = j_last ? S_SC_REQ : S_FW_J;
                end
            end
            S_BI_WR: begin
                cell_ctrl.fill = 1'b1;
                bt_we  = i_lt;
                i_next = i_reg + 1'b1;
                if (i_last) begin
                    i_next = '0;
                    if (t_reg == '0) begin
                        run_flags_next = {zero_reg, sat_reg};
                        res_next       = '{read_value: '0,
                                           status: code_of({zero_reg, sat_reg})};
                        state_next     = S_OUT;
                    end else begin
                        state_next = S_BW_I;
                    end
                end
            end
            S_BW_I: begin
                if (i_lt) begin
                    acc_next   = '0;
                    j_next     = '0;
                    state_next = S_BW_RD;
                end else begin
                    cell_ctrl.push = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = i_last ? S_BW_FIN : S_BW_I;
                end
            end
            S_BW_RD: begin
                if (j_lt) begin
                    state_next = S_BW_M1;
                end else begin
                    cell_ctrl.rot = 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = j_last ? S_BW_SC : S_BW_RD;
                end
            end
            S_BW_M1: begin
                mul_start  = 1'b1;
                mul_a      = tr_rd;
                mul_b      = dn_rd;
                state_next = S_BW_W1;
            end
            S_BW_W1: begin
                if (mul_done) begin
                    tmp_next   = mul_res;
                    sat_next   = sat_reg | mul_sat;
                    state_next = S_BW_M2;
                end
            end
            S_BW_M2: begin
                mul_start  = 1'b1;
                mul_a      = tmp_reg;
                mul_b      = prev0;
                state_next = S_BW_W2;
            end
            S_BW_W2: begin
                if (mul_done) begin
                    add_r      = sadd(acc_reg, mul_res);
                    acc_next   = add_r[63:0];
                    sat_next   = sat_reg | mul_sat | add_r[64];
                    cell_ctrl.rot = 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = j_last ? S_BW_SC : S_BW_RD;
                end
            end
            S_BW_SC: state_next = S_BW_M3;
            S_BW_M3: begin
                mul_start  = 1'b1;
                mul_a      = acc_reg;
                mul_b      = sc_rd;
                state_next = S_BW_W3;
            end
            S_BW_W3: begin
                if (mul_done) begin
                    cell_ctrl.push = 1'b1;
                    push_val   = mul_res;
                    bt_we      = 1'b1;
                    sat_next   = sat_reg | mul_sat;
                    i_next     = i_reg + 1'b1;
                    state_next = i_last ? S_BW_FIN : S_BW_I;
                end
            end
            S_BW_FIN: begin
                cell_ctrl.copy = 1'b1;
                i_next         = '0;
                if (t_reg == STEP_W'(1)) begin
                    run_flags_next = {zero_reg, sat_reg};
                    res_next       = '{read_value: '0, status: code_of({zero_reg, sat_reg})};
                    state_next     = S_OUT;
                end else begin
                    t_next     = t_prev;
                    state_next = S_BW_I;
                end
            end
            S_RD_RD: state_next = S_RD_DAT;
            S_RD_DAT: begin
                state_next = S_OUT;
                unique case (item_reg.which_array)
                    W_SCALE: begin
                        if (step_ok) begin
                            res_next = '{read_value: sc_rd, status: code_of(run_flags_reg)};
                        end
                    end
                    W_ALPHA: begin
                        if (rd_ok) begin
                            res_next = '{read_value: al_rd, status: code_of(run_flags_reg)};
                        end
                    end
                    W_BETA: begin
                        if (rd_ok) begin
                            res_next = '{read_value: bt_rd, status: code_of(run_flags_reg)};
                        end
                    end
                    default: begin
                        if (xi_ok) begin
                            mul_start  = 1'b1;
                            mul_a      = al_rd;
                            mul_b      = tr_rd;
                            state_next = S_XI_W1;
                        end
                    end
                endcase
            end
            S_XI_W1: begin
                if (mul_done) begin
                    tmp_next   = mul_res;
                    sat_next   = sat_reg | mul_sat;
                    state_next = S_XI_M2;
                end
            end
            S_XI_M2: begin
                mul_start  = 1'b1;
                mul_a      = tmp_reg;
                mul_b      = dn_rd;
                state_next = S_XI_W2;
            end
            S_XI_W2: begin
                if (mul_done) begin
                    tmp_next   = mul_res;
                    sat_next   = sat_reg | mul_sat;
                    state_next = S_XI_M3;
                end
            end
            S_XI_M3: begin
                mul_start  = 1'b1;
                mul_a      = tmp_reg;
                mul_b      = bt_rd;
                state_next = S_XI_W3;
            end
            S_XI_W3: begin
                if (mul_done) begin
                    res_next   = '{read_value: mul_res,
                                   status: code_of(run_flags_reg
                                                   | {1'b0, sat_reg | mul_sat})};
                    state_next = S_OUT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            run_flags_reg <= '0;
            m_valid_reg   <= 1'b0;
            homog_reg     <= 1'b1;
            nstates_reg   <= NSTATES_RST;
        end else begin
            state_reg     <= state_next;
            run_flags_reg <= run_flags_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_HOMOG:   homog_reg   <= cfg_data[0];
                    CFG_NSTATES: nstates_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        sum_reg    <= sum_next;
        sc_reg     <= sc_next;
        tmp_reg    <= tmp_next;
        sat_reg    <= sat_next;
        zero_reg   <= zero_next;
        len_reg    <= len_next;
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    for (genvar k = 0; k < MAX_STATES; k++) begin : g_cell
        logic [63:0] cur_in;
        if (k == MAX_STATES - 1) begin : g_tail
            assign cur_in = push_val;
        end else begin : g_body
            assign cur_in = cell_cur[k+1];
        end
        hmmfb_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .prev_in  (cell_prev[(k+1) % MAX_STATES]),
            .cur_in   (cur_in),
            .fill_val (sc_reg),
            .prev_q   (cell_prev[k]),
            .cur_q    (cell_cur[k])
        );
    end

    hmmfb_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .res     (mul_res),
        .sat     (mul_sat)
    );

    hmmfb_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rc_start),
        .divisor (sum_reg),
        .done    (rc_done),
        .quot    (rc_q),
        .sat     (rc_sat)
    );

    hmmfb_ram #(.WIDTH(DW), .DEPTH(MAX_STATES)) u_init_ram (
        .aclk (aclk), .we (init_we), .waddr (ST_W'(s_data.from_state)),
        .wdata (s_data.data_value), .raddr (init_ra), .rdata (init_rd)
    );

    hmmfb_ram #(.WIDTH(DW), .DEPTH(TR_DEPTH)) u_trans_ram (
        .aclk (aclk), .we (tr_we), .waddr (tr_wa),
        .wdata (s_data.data_value), .raddr (tr_ra), .rdata (tr_rd)
    );

    hmmfb_ram #(.WIDTH(DW), .DEPTH(ST_DEPTH)) u_dens_ram (
        .aclk (aclk), .we (dn_we), .waddr (dn_wa),
        .wdata (s_data.data_value), .raddr (dn_ra), .rdata (dn_rd)
    );

    hmmfb_ram #(.WIDTH(DW), .DEPTH(ST_DEPTH)) u_alpha_ram (
        .aclk (aclk), .we (al_we), .waddr (al_wa),
        .wdata (mul_res), .raddr (al_ra), .rdata (al_rd)
    );

    hmmfb_ram #(.WIDTH(DW), .DEPTH(ST_DEPTH)) u_beta_ram (
        .aclk (aclk), .we (bt_we), .waddr (bt_wa),
        .wdata (bt_wd), .raddr (bt_ra), .rdata (bt_rd)
    );

    hmmfb_ram #(.WIDTH(DW), .DEPTH(MAX_STEPS)) u_scale_ram (
        .aclk (aclk), .we (sc_we), .waddr (t_reg),
        .wdata (sc_reg), .raddr (sc_ra), .rdata (sc_rd)
    );

endmodule

/* hdl/hmmfb_ram.sv */
`timescale 1ns / 1ps

module hmmfb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

/* hdl/hmmfb_mul.sv */
`timescale 1ns / 1ps

module hmmfb_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res,
    output logic        sat
);
    import hmmfb_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    logic [2:0]   ph_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [127:0] prod_reg;
    logic [31:0]  a_h;
    logic [31:0]  b_h;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    assign a_h = ph_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_h = ph_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp  = a_h * b_h;

    always_comb begin
        unique case (sh_reg)
            2'd0:    pp_sh = {64'd0, pp_reg};
            2'd3:    pp_sh = {pp_reg, 64'd0};
            default: pp_sh = {32'd0, pp_reg, 32'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= '0;
        end else if (busy_reg) begin
            if (ph_reg != 3'd4) begin
                pp_reg <= pp;
                sh_reg <= ph_reg[1:0];
            end
            if (ph_reg != 3'd0) begin
                prod_reg <= prod_reg + pp_sh;
            end
        end
    end

    assign done = done_reg;
    assign sat  = prod_reg[127:FRAC_BITS+64] != '0;
    assign res  = sat ? ALL_ONES : prod_reg[FRAC_BITS+63:FRAC_BITS];

endmodule

/* hdl/hmmfb_recip.sv */
`timescale 1ns / 1ps

module hmmfb_recip (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quot,
    output logic        sat
);
    import hmmfb_pkg::*;

    localparam int CW = $clog2(2 * FRAC_BITS + 1);
    localparam logic [CW-1:0] TOP = CW'(2 * FRAC_BITS);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] b_reg;
    logic [63:0]   div_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   q_reg;
    logic          over_reg;
    logic [64:0]   r2;
    logic [64:0]   diff;
    logic          ge;

    assign r2   = {rem_reg, b_reg == TOP};
    assign ge   = r2 >= {1'b0, div_reg};
    assign diff = r2 - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && b_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg  <= divisor;
            rem_reg  <= '0;
            q_reg    <= '0;
            over_reg <= 1'b0;
            b_reg    <= TOP;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[63:0] : r2[63:0];
            q_reg   <= {q_reg[62:0], ge};
            if (ge && 32'(b_reg) > 63) begin
                over_reg <= 1'b1;
            end
            b_reg <= b_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign sat  = over_reg;
    assign quot = over_reg ? ALL_ONES : q_reg;

endmodule

/* hdl/hmmfb_cell.sv */
`timescale 1ns / 1ps

module hmmfb_cell (
    input  logic                   aclk,
    input  hmmfb_pkg::cell_ctrl_t  ctrl,
    input  logic [63:0]            prev_in,
    input  logic [63:0]            cur_in,
    input  logic [63:0]            fill_val,
    output logic [63:0]            prev_q,
    output logic [63:0]            cur_q
);
    import hmmfb_pkg::*;

    logic [63:0] prev_reg;
    logic [63:0] cur_reg;

    always_ff @(posedge aclk) begin
        priority if (ctrl.fill) begin
            prev_reg <= fill_val;
        end else if (ctrl.copy) begin
            prev_reg <= cur_reg;
        end else if (ctrl.rot) begin
            prev_reg <= prev_in;
        end
        if (ctrl.push) begin
            cur_reg <= cur_in;
        end
    end

    assign prev_q = prev_reg;
    assign cur_q  = cur_reg;

endmodule
